// ----- hdl/bblc_pkg.sv -----
// Shared types and codes for the byte-budget LRU cache table.
`default_nettype none
package bblc_pkg;

	localparam int SLOT_IDX_W = 8;

	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_STORE  = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [2:0] ST_HIT        = 3'd0;
	localparam logic [2:0] ST_MISS       = 3'd1;
	localparam logic [2:0] ST_STALE      = 3'd2;
	localparam logic [2:0] ST_STORED     = 3'd3;
	localparam logic [2:0] ST_TOO_LARGE  = 3'd4;
	localparam logic [2:0] ST_REMOVED    = 3'd5;
	localparam logic [2:0] ST_ABSENT     = 3'd6;

	typedef struct packed {
		logic [1:0]         mode;
		logic [63:0]        entry_key;
		logic [31:0]        body_bytes;
		logic [62:0]        file_size;
		logic signed [63:0] file_mtime;
		logic [63:0]        file_device;
		logic [63:0]        file_inode;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  slot_index;
		logic [4:0]  evicted_count;
		logic [31:0] bytes_in_use;
	} result_t;

	typedef struct packed {
		logic [62:0]        file_size;
		logic signed [63:0] file_mtime;
		logic [63:0]        file_device;
		logic [63:0]        file_inode;
	} stamp_t;

	// Search record that travels down the row of slots.
	typedef struct packed {
		logic                  match_v;
		logic                  stamp_ok;
		logic [SLOT_IDX_W-1:0] match_idx;
		logic [31:0]           match_body;
		logic                  lru_v;
		logic [SLOT_IDX_W-1:0] lru_idx;
		logic [63:0]           lru_tick;
		logic [31:0]           lru_body;
		logic                  free_v;
		logic [SLOT_IDX_W-1:0] free_idx;
	} rec_t;

	// Update command broadcast to every slot.
	typedef struct packed {
		logic                  drop;
		logic                  touch;
		logic                  wr;
		logic [SLOT_IDX_W-1:0] idx;
		logic [63:0]           tick;
		logic [31:0]           body;
	} cmd_t;

endpackage
`default_nettype wire

// ----- hdl/bblc_cell.sv -----
// One slot of the table with its stage of the search record.
`default_nettype none
module bblc_cell #(
	parameter int ID = 0
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire [63:0]                 qkey,
	input  wire bblc_pkg::stamp_t      qstamp,
	input  wire bblc_pkg::cmd_t        cmd,
	input  wire bblc_pkg::rec_t        rec_in,
	output bblc_pkg::rec_t             rec_out
);
	import bblc_pkg::*;

	logic        valid_q;
	logic [63:0] key_q;
	logic [31:0] body_q;
	stamp_t      stamp_q;
	logic [63:0] tick_q;
	rec_t        rec_q;
	rec_t        rec_d;
	logic        hit_me;

	assign hit_me = (cmd.idx == SLOT_IDX_W'(ID));

	always_comb begin
		rec_d = rec_in;
		if (valid_q && key_q == qkey && !rec_in.match_v) begin
			rec_d.match_v    = 1'b1;
			rec_d.match_idx  = SLOT_IDX_W'(ID);
			rec_d.match_body = body_q;
			rec_d.stamp_ok   = (stamp_q == qstamp);
		end
		if (valid_q && (!rec_in.lru_v || tick_q < rec_in.lru_tick)) begin
			rec_d.lru_v    = 1'b1;
			rec_d.lru_idx  = SLOT_IDX_W'(ID);
			rec_d.lru_tick = tick_q;
			rec_d.lru_body = body_q;
		end
		if (!valid_q && !rec_in.free_v) begin
			rec_d.free_v   = 1'b1;
			rec_d.free_idx = SLOT_IDX_W'(ID);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (hit_me && cmd.drop) begin
			valid_q <= 1'b0;
		end else if (hit_me && cmd.wr) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rec_q <= rec_d;
		if (hit_me && cmd.wr) begin
			key_q   <= qkey;
			body_q  <= cmd.body;
			stamp_q <= qstamp;
		end
		if (hit_me && (cmd.wr || cmd.touch)) begin
			tick_q <= cmd.tick;
		end
	end

	assign rec_out = rec_q;

endmodule
`default_nettype wire

// ----- hdl/byte_budget_lru_cache_table_core.sv -----
// Top level: control sequencer and the row of slots of the LRU cache table.
//
//  channel   ports                     transfer
//  command   start, busy, item         start high while busy low
//  result    done, result              done high, one cycle, no stall
//  config    cfg_we, cfg_wdata         cfg_we high
//
// A search pass walks the record through all ENTRIES slots, one per cycle,
// and then decides. Lookup and remove take one pass; a store takes one pass
// plus one more for each slot it frees. Mode 3 and oversized stores finish
// without a pass. Reset clears all slot valid bits at once. The result
// appears on the cycle after the item completes and cannot be held off.
`default_nettype none
module byte_budget_lru_cache_table_core #(
	parameter int ENTRIES = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	output logic                     busy,
	input  wire bblc_pkg::item_t     item,
	input  wire                      cfg_we,
	input  wire [31:0]               cfg_wdata,
	output logic                     done,
	output bblc_pkg::result_t        result
);
	import bblc_pkg::*;

	localparam int CW = $clog2(ENTRIES);

	typedef enum logic [1:0] {S_IDLE, S_PASS, S_DECIDE} state_t;

	state_t      state_q;
	logic [CW-1:0] cnt_q;
	item_t       it_q;
	logic [31:0] budget_q;
	logic [31:0] total_q;
	logic [63:0] uc_q;
	logic [4:0]  ev_q;
	logic        done_q;
	result_t     res_q;

	rec_t        chain [ENTRIES+1];
	rec_t        rec;
	stamp_t      qstamp;
	cmd_t        cmd;
	logic        fin;
	logic [2:0]  st_d;
	logic [SLOT_IDX_W-1:0] slot_d;
	logic [31:0] total_d;
	logic [63:0] uc_d;
	logic [4:0]  ev_d;
	logic [32:0] need;

	assign chain[0] = '0;
	assign rec      = chain[ENTRIES];
	assign qstamp   = '{it_q.file_size, it_q.file_mtime, it_q.file_device, it_q.file_inode};

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		bblc_cell #(.ID(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.qkey   (it_q.entry_key),
			.qstamp (qstamp),
			.cmd    (cmd),
			.rec_in (chain[g]),
			.rec_out(chain[g+1])
		);
	end

	assign need = {1'b0, total_q} + {1'b0, it_q.body_bytes};

	always_comb begin
		cmd     = '0;
		fin     = 1'b0;
		st_d    = ST_MISS;
		slot_d  = '0;
		total_d = total_q;
		uc_d    = uc_q;
		ev_d    = ev_q;
		if (state_q == S_DECIDE) begin
			case (it_q.mode)
				MODE_LOOKUP: begin
					fin = 1'b1;
					if (!rec.match_v) begin
						st_d = ST_MISS;
					end else if (!rec.stamp_ok) begin
						cmd.drop = 1'b1;
						cmd.idx  = rec.match_idx;
						total_d  = total_q - rec.match_body;
						st_d     = ST_STALE;
						ev_d     = 5'd1;
					end else begin
						uc_d      = uc_q + 64'd1;
						cmd.touch = 1'b1;
						cmd.idx   = rec.match_idx;
						cmd.tick  = uc_d;
						st_d      = ST_HIT;
						slot_d    = rec.match_idx;
					end
				end
				MODE_STORE: begin
					if (rec.match_v) begin
						cmd.drop = 1'b1;
						cmd.idx  = rec.match_idx;
						total_d  = total_q - rec.match_body;
						ev_d     = ev_q + 5'd1;
					end else if ((need > {1'b0, budget_q} && rec.lru_v) || !rec.free_v) begin
						cmd.drop = 1'b1;
						cmd.idx  = rec.lru_idx;
						total_d  = total_q - rec.lru_body;
						ev_d     = ev_q + 5'd1;
					end else begin
						fin      = 1'b1;
						uc_d     = uc_q + 64'd1;
						cmd.wr   = 1'b1;
						cmd.idx  = rec.free_idx;
						cmd.tick = uc_d;
						cmd.body = it_q.body_bytes;
						total_d  = need[31:0];
						st_d     = ST_STORED;
						slot_d   = rec.free_idx;
					end
				end
				MODE_REMOVE: begin
					fin = 1'b1;
					if (rec.match_v) begin
						cmd.drop = 1'b1;
						cmd.idx  = rec.match_idx;
						total_d  = total_q - rec.match_body;
						st_d     = ST_REMOVED;
						ev_d     = 5'd1;
					end else begin
						st_d = ST_ABSENT;
					end
				end
				default: begin
					fin = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			it_q     <= '0;
			budget_q <= 32'd67108864;
			total_q  <= '0;
			uc_q     <= '0;
			ev_q     <= '0;
			done_q   <= 1'b0;
			res_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				budget_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						it_q <= item;
						ev_q <= '0;
						cnt_q <= '0;
						if (item.mode == MODE_STORE && item.body_bytes > budget_q) begin
							done_q <= 1'b1;
							res_q  <= '{ST_TOO_LARGE, 4'd0, 5'd0, total_q};
						end else if (item.mode != MODE_LOOKUP && item.mode != MODE_STORE
								&& item.mode != MODE_REMOVE) begin
							done_q <= 1'b1;
							res_q  <= '{ST_MISS, 4'd0, 5'd0, total_q};
						end else begin
							state_q <= S_PASS;
						end
					end
				end
				S_PASS: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(ENTRIES - 1)) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					total_q <= total_d;
					uc_q    <= uc_d;
					ev_q    <= ev_d;
					cnt_q   <= '0;
					if (fin) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						res_q   <= '{st_d, 4'(slot_d), ev_d, total_d};
					end else begin
						state_q <= S_PASS;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire
